/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is held low.
`define LRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lrs assertion failed");

// Condition that must never be seen at a clock edge.
`define LRS_NEVER(lbl, clk, rst_n, cond) \
  `LRS_ASSERT(lbl, clk, rst_n, !(cond))

`endif

/* rtl/core/lrs_pkg.sv */
package lrs_pkg;

  localparam int unsigned LOSS_SCALE_DEF    = 100;
  localparam int unsigned FINE_SCALE_DEF    = 100;
  localparam int unsigned MS_PER_SECOND_DEF = 1000;
  localparam int unsigned US_PER_MS         = 1000;
  localparam int unsigned BPS_PER_KBPS      = 1000;
  localparam logic [31:0] INTERVAL_RESET    = 32'd1000000;

  // Widest constant multiplier (LOSS_SCALE * FINE_SCALE or microseconds per second)
  localparam int MULK_W = 20;
  localparam int NUM_W  = 64 + MULK_W;
  localparam int DIV_W  = 33;
  localparam int CNT_W  = $clog2(NUM_W + 1);

  localparam int LOSS_W = 7;
  localparam int FINE_W = 14;
  localparam int RATE_W = 32;

  localparam int IN_TDATA_W  = 240;
  localparam int OUT_TDATA_W = 272;
  localparam int OUT_TUSER_W = 1;

  typedef struct packed {
    logic [31:0] elapsed_us;
    logic [39:0] recv_bits;
    logic [31:0] recv_packets;
    logic [31:0] highest_packet_number;
    logic [31:0] sent_packets;
    logic [31:0] sent_lost_packets;
    logic [39:0] sent_bits;
  } lrs_item_t;

  typedef struct packed {
    logic [LOSS_W-1:0] tick_loss;
    logic [RATE_W-1:0] tick_rate_kbps;
    logic [RATE_W-1:0] peak_rate_kbps;
    logic              long_valid;
    logic [FINE_W-1:0] long_recv_loss_fine;
    logic [LOSS_W-1:0] long_recv_loss;
    logic [63:0]       long_recv_rate_bps;
    logic [RATE_W-1:0] long_recv_rate_kbps;
    logic [FINE_W-1:0] long_send_loss_fine;
    logic [63:0]       long_send_rate_bps;
  } lrs_res_t;

  // Request to the shared multiply-divide unit: floor(a * k / d)
  typedef struct packed {
    logic              start;
    logic [63:0]       a;
    logic [MULK_W-1:0] k;
    logic [CNT_W-1:0]  kw;
    logic [DIV_W-1:0]  d;
    logic [CNT_W-1:0]  nw;
  } md_req_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_ACC,
    SQ_TLOSS,
    SQ_TRATE,
    SQ_LFINE,
    SQ_LCOARSE,
    SQ_LBPS,
    SQ_LKBPS,
    SQ_SFINE,
    SQ_SBPS,
    SQ_DONE
  } sq_state_t;

endpackage

/* rtl/core/lrs_muldiv.sv */
`include "assert_macros.svh"

module lrs_muldiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lrs_pkg::md_req_t           req,
  output logic                       done,
  output logic [lrs_pkg::NUM_W-1:0]  quo
);
  import lrs_pkg::*;

  localparam int KIDX_W = $clog2(MULK_W);
  localparam int NIDX_W = $clog2(NUM_W);

  md_state_t         st_r, st_nxt;
  logic [63:0]       a_r, a_nxt;
  logic [MULK_W-1:0] k_r, k_nxt;
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  nw_r, nw_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic              done_r, done_nxt;
  logic              nbit;
  logic [DIV_W:0]    part;
  logic [DIV_W:0]    trial;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      MD_IDLE: begin
        if (req.start) st_nxt = MD_MUL;
      end
      MD_MUL: begin
        if (cnt_r == '0) st_nxt = MD_DIV;
      end
      MD_DIV: begin
        if (cnt_r == '0) st_nxt = MD_IDLE;
      end
      default: st_nxt = MD_IDLE;
    endcase
  end

  assign nbit  = acc_r[cnt_r[NIDX_W-1:0]];
  assign part  = {rem_r, nbit};
  assign trial = part - {1'b0, d_r};

  always_comb begin
    a_nxt    = a_r;
    k_nxt    = k_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    nw_nxt   = nw_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    case (st_r)
      MD_IDLE: begin
        if (req.start) begin
          a_nxt   = req.a;
          k_nxt   = req.k;
          d_nxt   = req.d;
          nw_nxt  = req.nw;
          cnt_nxt = req.kw - CNT_W'(1);
          acc_nxt = '0;
        end
      end
      MD_MUL: begin
        // MSB-first shift and add over the constant's bits
        acc_nxt = {acc_r[NUM_W-2:0], 1'b0} +
                  (k_r[cnt_r[KIDX_W-1:0]] ? NUM_W'(a_r) : NUM_W'(0));
        if (cnt_r == '0) begin
          cnt_nxt = nw_r - CNT_W'(1);
          rem_nxt = '0;
          quo_nxt = '0;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      MD_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!trial[DIV_W]) begin
          rem_nxt = trial[DIV_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = part[DIV_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    k_r   <= k_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    nw_r  <= nw_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

  `LRS_ASSERT(a_rem_below_div, clk, rst_n, (st_r == MD_DIV) |-> (rem_r < d_r))
  `LRS_ASSERT(a_done_after_div, clk, rst_n, done_r |-> ($past(st_r) == MD_DIV))
  `LRS_ASSERT(a_start_when_idle, clk, rst_n, req.start |-> (st_r == MD_IDLE))

endmodule

/* rtl/core/lrs_seq.sv */
`include "assert_macros.svh"

module lrs_seq #(
  parameter int unsigned LOSS_SCALE    = lrs_pkg::LOSS_SCALE_DEF,
  parameter int unsigned FINE_SCALE    = lrs_pkg::FINE_SCALE_DEF,
  parameter int unsigned MS_PER_SECOND = lrs_pkg::MS_PER_SECOND_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  lrs_pkg::lrs_item_t        item,
  input  logic [31:0]               interval,
  output logic                      res_valid,
  input  logic                      res_ready,
  output lrs_pkg::lrs_res_t         res,
  output lrs_pkg::md_req_t          md_req,
  input  logic                      md_done,
  input  logic [lrs_pkg::NUM_W-1:0] md_quo
);
  import lrs_pkg::*;

  localparam int unsigned LF = LOSS_SCALE * FINE_SCALE;
  localparam int unsigned US = MS_PER_SECOND * US_PER_MS;
  localparam int KW_LOSS = $clog2(LOSS_SCALE + 1);
  localparam int KW_MS   = $clog2(MS_PER_SECOND + 1);
  localparam int KW_LF   = $clog2(LF + 1);
  localparam int KW_US   = $clog2(US + 1);

  sq_state_t         st_r, st_nxt;
  logic              wait_r, wait_nxt;
  logic              long_r, long_nxt;
  lrs_item_t         item_r, item_nxt;
  logic [31:0]       prev_rate_r, prev_rate_nxt;
  logic [31:0]       peak_r, peak_nxt;
  logic [31:0]       tick_base_r, tick_base_nxt;
  logic [31:0]       long_base_r, long_base_nxt;
  logic [DIV_W-1:0]  time_sum_r, time_sum_nxt;
  logic [63:0]       rbits_sum_r, rbits_sum_nxt;
  logic [31:0]       rpkts_sum_r, rpkts_sum_nxt;
  logic [31:0]       spkts_sum_r, spkts_sum_nxt;
  logic [31:0]       lost_sum_r, lost_sum_nxt;
  logic [63:0]       sbits_sum_r, sbits_sum_nxt;
  logic [LOSS_W-1:0] tl_r, tl_nxt;
  logic [31:0]       rate_r, rate_nxt;
  logic [FINE_W-1:0] fine_r, fine_nxt;
  logic [LOSS_W-1:0] coarse_r, coarse_nxt;
  logic [63:0]       bps_r, bps_nxt;
  logic [31:0]       kbps_r, kbps_nxt;
  logic [FINE_W-1:0] sfine_r, sfine_nxt;
  logic [63:0]       sbps_r, sbps_nxt;

  logic [31:0]       adv_t, adv_l;
  logic              tl_go, lf_go, sf_go, op_go, op_fin;
  logic [64:0]       rbits_add, sbits_add;
  logic [32:0]       avg_sum;
  logic [31:0]       avg;
  logic [31:0]       sat32;
  logic [63:0]       sat64;
  logic              start_w;
  logic [63:0]       op_a;
  logic [MULK_W-1:0] op_k;
  logic [CNT_W-1:0]  op_kw;
  logic [DIV_W-1:0]  op_d;
  logic [CNT_W-1:0]  op_nw;

  assign adv_t = item_r.highest_packet_number - tick_base_r;
  assign adv_l = item_r.highest_packet_number - long_base_r;
  assign tl_go = (adv_t != '0) && (adv_t > item_r.recv_packets);
  assign lf_go = (adv_l != '0) && (adv_l >= rpkts_sum_r);
  assign sf_go = (spkts_sum_r != '0) && (spkts_sum_r >= lost_sum_r);

  always_comb begin
    case (st_r)
      SQ_TLOSS:   op_go = tl_go;
      SQ_LFINE:   op_go = lf_go;
      SQ_LCOARSE: op_go = lf_go;
      SQ_SFINE:   op_go = sf_go;
      default:    op_go = 1'b1;
    endcase
  end

  // An operation finishes when the unit reports done, or at once when skipped
  assign op_fin = wait_r ? md_done : !op_go;

  assign sat32 = (md_quo[NUM_W-1:32] != '0) ? '1 : md_quo[31:0];
  assign sat64 = (md_quo[NUM_W-1:64] != '0) ? '1 : md_quo[63:0];

  assign rbits_add = {1'b0, rbits_sum_r} + 65'(item_r.recv_bits);
  assign sbits_add = {1'b0, sbits_sum_r} + 65'(item_r.sent_bits);

  assign avg_sum = {1'b0, prev_rate_r} + {1'b0, rate_r};
  assign avg     = avg_sum[32:1];

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      SQ_IDLE:    if (item_valid) st_nxt = SQ_ACC;
      SQ_ACC:     st_nxt = SQ_TLOSS;
      SQ_TLOSS:   if (op_fin) st_nxt = SQ_TRATE;
      SQ_TRATE:   if (op_fin) st_nxt = long_r ? SQ_LFINE : SQ_DONE;
      SQ_LFINE:   if (op_fin) st_nxt = SQ_LCOARSE;
      SQ_LCOARSE: if (op_fin) st_nxt = SQ_LBPS;
      SQ_LBPS:    if (op_fin) st_nxt = SQ_LKBPS;
      SQ_LKBPS:   if (op_fin) st_nxt = SQ_SFINE;
      SQ_SFINE:   if (op_fin) st_nxt = SQ_SBPS;
      SQ_SBPS:    if (op_fin) st_nxt = SQ_DONE;
      SQ_DONE:    if (res_ready) st_nxt = SQ_IDLE;
      default:    st_nxt = SQ_IDLE;
    endcase
  end

  // Operand selection for the shared unit
  always_comb begin
    op_a  = '0;
    op_k  = MULK_W'(1);
    op_kw = CNT_W'(1);
    op_d  = DIV_W'(1);
    op_nw = CNT_W'(1);
    case (st_r)
      SQ_TLOSS: begin
        op_a  = 64'(adv_t - item_r.recv_packets);
        op_k  = MULK_W'(LOSS_SCALE);
        op_kw = CNT_W'(KW_LOSS);
        op_d  = DIV_W'(adv_t);
        op_nw = CNT_W'(32 + KW_LOSS);
      end
      SQ_TRATE: begin
        op_a  = 64'(item_r.recv_bits);
        op_k  = MULK_W'(MS_PER_SECOND);
        op_kw = CNT_W'(KW_MS);
        op_d  = DIV_W'(item_r.elapsed_us);
        op_nw = CNT_W'(40 + KW_MS);
      end
      SQ_LFINE: begin
        op_a  = 64'(adv_l - rpkts_sum_r);
        op_k  = MULK_W'(LF);
        op_kw = CNT_W'(KW_LF);
        op_d  = DIV_W'(adv_l);
        op_nw = CNT_W'(32 + KW_LF);
      end
      SQ_LCOARSE: begin
        // fine / FINE_SCALE folds into one ratio with the coarse scale
        op_a  = 64'(adv_l - rpkts_sum_r);
        op_k  = MULK_W'(LOSS_SCALE);
        op_kw = CNT_W'(KW_LOSS);
        op_d  = DIV_W'(adv_l);
        op_nw = CNT_W'(32 + KW_LOSS);
      end
      SQ_LBPS: begin
        op_a  = rbits_sum_r;
        op_k  = MULK_W'(US);
        op_kw = CNT_W'(KW_US);
        op_d  = time_sum_r;
        op_nw = CNT_W'(64 + KW_US);
      end
      SQ_LKBPS: begin
        // bps / 1000 folds into bits * MS_PER_SECOND / time
        op_a  = rbits_sum_r;
        op_k  = MULK_W'(MS_PER_SECOND);
        op_kw = CNT_W'(KW_MS);
        op_d  = time_sum_r;
        op_nw = CNT_W'(64 + KW_MS);
      end
      SQ_SFINE: begin
        op_a  = 64'(lost_sum_r);
        op_k  = MULK_W'(LF);
        op_kw = CNT_W'(KW_LF);
        op_d  = DIV_W'(spkts_sum_r);
        op_nw = CNT_W'(32 + KW_LF);
      end
      SQ_SBPS: begin
        op_a  = sbits_sum_r;
        op_k  = MULK_W'(US);
        op_kw = CNT_W'(KW_US);
        op_d  = time_sum_r;
        op_nw = CNT_W'(64 + KW_US);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    wait_nxt      = wait_r;
    long_nxt      = long_r;
    item_nxt      = item_r;
    prev_rate_nxt = prev_rate_r;
    peak_nxt      = peak_r;
    tick_base_nxt = tick_base_r;
    long_base_nxt = long_base_r;
    time_sum_nxt  = time_sum_r;
    rbits_sum_nxt = rbits_sum_r;
    rpkts_sum_nxt = rpkts_sum_r;
    spkts_sum_nxt = spkts_sum_r;
    lost_sum_nxt  = lost_sum_r;
    sbits_sum_nxt = sbits_sum_r;
    tl_nxt        = tl_r;
    rate_nxt      = rate_r;
    fine_nxt      = fine_r;
    coarse_nxt    = coarse_r;
    bps_nxt       = bps_r;
    kbps_nxt      = kbps_r;
    sfine_nxt     = sfine_r;
    sbps_nxt      = sbps_r;
    start_w       = 1'b0;
    res_valid     = 1'b0;

    case (st_r)
      SQ_IDLE: begin
        if (item_valid) begin
          item_nxt = item;
          if (item.elapsed_us == '0) item_nxt.elapsed_us = 32'd1;
        end
      end
      SQ_ACC: begin
        time_sum_nxt  = time_sum_r + DIV_W'(item_r.elapsed_us);
        long_nxt      = (time_sum_r + DIV_W'(item_r.elapsed_us)) >= DIV_W'(interval);
        rbits_sum_nxt = rbits_add[64] ? '1 : rbits_add[63:0];
        sbits_sum_nxt = sbits_add[64] ? '1 : sbits_add[63:0];
        rpkts_sum_nxt = rpkts_sum_r + item_r.recv_packets;
        spkts_sum_nxt = spkts_sum_r + item_r.sent_packets;
        lost_sum_nxt  = lost_sum_r + item_r.sent_lost_packets;
      end
      SQ_DONE: begin
        if (res_ready) begin
          res_valid     = 1'b1;
          prev_rate_nxt = rate_r;
          if (peak_r < avg) peak_nxt = avg;
          tick_base_nxt = item_r.highest_packet_number;
          if (long_r) begin
            time_sum_nxt  = '0;
            rbits_sum_nxt = '0;
            rpkts_sum_nxt = '0;
            spkts_sum_nxt = '0;
            lost_sum_nxt  = '0;
            sbits_sum_nxt = '0;
            long_base_nxt = item_r.highest_packet_number;
          end
        end
      end
      default: begin
        // one operation state: launch, skip with a zero result, or collect
        if (!wait_r) begin
          if (op_go) begin
            start_w  = 1'b1;
            wait_nxt = 1'b1;
          end else begin
            case (st_r)
              SQ_TLOSS:   tl_nxt     = '0;
              SQ_LFINE:   fine_nxt   = '0;
              SQ_LCOARSE: coarse_nxt = '0;
              SQ_SFINE:   sfine_nxt  = '0;
              default:    tl_nxt     = tl_r;
            endcase
          end
        end else if (md_done) begin
          wait_nxt = 1'b0;
          case (st_r)
            SQ_TLOSS:   tl_nxt     = md_quo[LOSS_W-1:0];
            SQ_TRATE:   rate_nxt   = sat32;
            SQ_LFINE:   fine_nxt   = md_quo[FINE_W-1:0];
            SQ_LCOARSE: coarse_nxt = md_quo[LOSS_W-1:0];
            SQ_LBPS:    bps_nxt    = sat64;
            SQ_LKBPS:   kbps_nxt   = sat32;
            SQ_SFINE:   sfine_nxt  = md_quo[FINE_W-1:0];
            SQ_SBPS:    sbps_nxt   = sat64;
            default:    wait_nxt   = 1'b0;
          endcase
        end
      end
    endcase
  end

  assign item_ready = (st_r == SQ_IDLE);

  assign md_req.start = start_w;
  assign md_req.a     = op_a;
  assign md_req.k     = op_k;
  assign md_req.kw    = op_kw;
  assign md_req.d     = op_d;
  assign md_req.nw    = op_nw;

  assign res.tick_loss           = tl_r;
  assign res.tick_rate_kbps      = avg;
  assign res.peak_rate_kbps      = (peak_r < avg) ? avg : peak_r;
  assign res.long_valid          = long_r;
  assign res.long_recv_loss_fine = long_r ? fine_r : '0;
  assign res.long_recv_loss      = long_r ? coarse_r : '0;
  assign res.long_recv_rate_bps  = long_r ? bps_r : '0;
  assign res.long_recv_rate_kbps = long_r ? kbps_r : '0;
  assign res.long_send_loss_fine = long_r ? sfine_r : '0;
  assign res.long_send_rate_bps  = long_r ? sbps_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= SQ_IDLE;
      wait_r      <= 1'b0;
      long_r      <= 1'b0;
      prev_rate_r <= '0;
      peak_r      <= '0;
      tick_base_r <= '0;
      long_base_r <= '0;
      time_sum_r  <= '0;
      rbits_sum_r <= '0;
      rpkts_sum_r <= '0;
      spkts_sum_r <= '0;
      lost_sum_r  <= '0;
      sbits_sum_r <= '0;
    end else begin
      st_r        <= st_nxt;
      wait_r      <= wait_nxt;
      long_r      <= long_nxt;
      prev_rate_r <= prev_rate_nxt;
      peak_r      <= peak_nxt;
      tick_base_r <= tick_base_nxt;
      long_base_r <= long_base_nxt;
      time_sum_r  <= time_sum_nxt;
      rbits_sum_r <= rbits_sum_nxt;
      rpkts_sum_r <= rpkts_sum_nxt;
      spkts_sum_r <= spkts_sum_nxt;
      lost_sum_r  <= lost_sum_nxt;
      sbits_sum_r <= sbits_sum_nxt;
    end
    item_r   <= item_nxt;
    tl_r     <= tl_nxt;
    rate_r   <= rate_nxt;
    fine_r   <= fine_nxt;
    coarse_r <= coarse_nxt;
    bps_r    <= bps_nxt;
    kbps_r   <= kbps_nxt;
    sfine_r  <= sfine_nxt;
    sbps_r   <= sbps_nxt;
  end

  `LRS_ASSERT(a_md_done_expected, clk, rst_n, md_done |-> wait_r)
  `LRS_ASSERT(a_sums_clear, clk, rst_n, (res_valid && long_r) |=> (time_sum_r == '0))
  `LRS_ASSERT(a_base_follows, clk, rst_n,
    res_valid |=> (tick_base_r == $past(item_r.highest_packet_number)))

endmodule

/* rtl/core/link_loss_and_rate_statistics.sv */
// Datapath: one shared shift-add multiply / restoring divide unit runs every ratio, one
//   bit per cycle; a tick that closes a long interval runs further ratios than a plain tick.
// Throughput: one tick at a time; in_tready stays low until the result is in the
//   output register, which holds it while the next tick is taken.
// Reset: rst_n synchronous, active low; clears the running sums, peak rate and packet bases, interval to 1000000 us.
module link_loss_and_rate_statistics #(
  parameter int unsigned LOSS_SCALE    = lrs_pkg::LOSS_SCALE_DEF,
  parameter int unsigned FINE_SCALE    = lrs_pkg::FINE_SCALE_DEF,
  parameter int unsigned MS_PER_SECOND = lrs_pkg::MS_PER_SECOND_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // elapsed_us, recv_bits, recv_packets, highest_packet_number,
  // sent_packets, sent_lost_packets, sent_bits
  input  logic [lrs_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tick_loss, tick_rate_kbps, peak_rate_kbps, long_recv_loss_fine, long_recv_loss,
  // long_recv_rate_bps, long_recv_rate_kbps, long_send_loss_fine, long_send_rate_bps
  output logic [lrs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // long_valid
  output logic [lrs_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [31:0]                      cfg_data
);
  import lrs_pkg::*;

  lrs_item_t               item;
  lrs_res_t                res;
  md_req_t                 md_req;
  logic                    md_done;
  logic [NUM_W-1:0]        md_quo;
  logic                    res_valid;
  logic                    res_ready;
  logic [31:0]             interval_r, interval_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0]  out_tuser_r, out_tuser_nxt;

  assign item.elapsed_us            = in_tdata[31:0];
  assign item.recv_bits             = in_tdata[71:32];
  assign item.recv_packets          = in_tdata[103:72];
  assign item.highest_packet_number = in_tdata[135:104];
  assign item.sent_packets          = in_tdata[167:136];
  assign item.sent_lost_packets     = in_tdata[199:168];
  assign item.sent_bits             = in_tdata[239:200];

  assign cfg_ready = 1'b1;
  assign res_ready = !out_tvalid_r || out_tready;

  lrs_seq #(
    .LOSS_SCALE    (LOSS_SCALE),
    .FINE_SCALE    (FINE_SCALE),
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .interval   (interval_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .md_req     (md_req),
    .md_done    (md_done),
    .md_quo     (md_quo)
  );

  lrs_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .done  (md_done),
    .quo   (md_quo)
  );

  always_comb begin
    interval_nxt = interval_r;
    if (cfg_valid) interval_nxt = cfg_data;
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    if (res_valid) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {6'd0,
                        res.long_send_rate_bps,
                        res.long_send_loss_fine,
                        res.long_recv_rate_kbps,
                        res.long_recv_rate_bps,
                        res.long_recv_loss,
                        res.long_recv_loss_fine,
                        res.peak_rate_kbps,
                        res.tick_rate_kbps,
                        res.tick_loss};
      out_tuser_nxt  = res.long_valid;
    end else if (out_tready) begin
      // drop valid once the transfer completes
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      interval_r   <= interval_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
